@@ design/tws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and codes for the text word splitter: result kinds, held
// mark codes, and the per-byte result plan passed from front to back.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int MAX_RES = 6;

    // result kinds
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_END_TOKEN = 2'd1;
    localparam logic [1:0] KIND_END_TEXT  = 2'd2;

    // held mark codes
    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_APOS   = 2'd1;
    localparam logic [1:0] MARK_HYPHEN = 2'd2;

    // byte codes
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } t_res;

    typedef struct packed {
        logic [2:0]               count;
        t_res [MAX_RES-1:0]       slot;
    } t_plan;

endpackage

@@ design/tws_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_front
// Accepts text bytes, classifies them against the open word and the held
// mark, and produces the full list of results each byte causes.
// ----------------------------------------------------------------------------
module tws_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_text_byte,
    input  logic           i_final_byte,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output tws_pkg::t_plan o_push_plan
);
    import tws_pkg::*;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] first;
        logic [7:0] second;
    } t_word;

    typedef struct packed {
        t_plan plan;
        t_word word;
    } t_ctx;

    function automatic logic f_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic f_word_byte(input logic [7:0] c);
        return c[7] || f_letter(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic f_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] f_fold(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    function automatic logic f_contraction(input t_word w);
        logic [7:0] a;
        logic       res;
        a   = f_fold(w.first);
        res = 1'b0;
        if (w.len == 2'd1) begin
            res = a inside {8'h6C, 8'h64, 8'h63, 8'h6A, 8'h6D, 8'h74, 8'h73, 8'h6E};
        end else if (w.len == 2'd2) begin
            res = (a == 8'h71) && (f_fold(w.second) == 8'h75);
        end
        return res;
    endfunction

    function automatic t_ctx f_emit(input t_ctx x, input logic [1:0] k,
                                    input logic [7:0] v);
        t_ctx y;
        y = x;
        if (y.plan.count < 3'(MAX_RES)) begin
            y.plan.slot[y.plan.count].kind  = k;
            y.plan.slot[y.plan.count].value = v;
            y.plan.count = y.plan.count + 3'd1;
        end
        return y;
    endfunction

    function automatic t_ctx f_append(input t_ctx x, input logic [7:0] b);
        t_ctx y;
        y = f_emit(x, KIND_BYTE, b);
        if (x.word.len == 2'd0) begin
            y.word.first = b;
        end else if (x.word.len == 2'd1) begin
            y.word.second = b;
        end
        if (x.word.len != 2'd3) begin
            y.word.len = x.word.len + 2'd1;
        end
        return y;
    endfunction

    function automatic t_ctx f_close(input t_ctx x);
        t_ctx y;
        y = x;
        if (x.word.len != 2'd0) begin
            y = f_emit(x, KIND_END_TOKEN, 8'h00);
        end
        y.word = '0;
        return y;
    endfunction

    logic [1:0] r_held, n_held;
    t_word      r_word;
    t_word      n_word;
    t_ctx       w_ctx;
    logic [7:0] w_mark;
    logic       w_accept;

    assign o_in_ready = i_push_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // work out the results of this byte and the state it leaves
    always_comb begin
        w_ctx.plan = '0;
        w_ctx.word = r_word;
        n_held     = r_held;
        w_mark     = (r_held == MARK_APOS) ? CH_APOS : CH_HYPHEN;

        // resolve a held mark against the new byte first
        if (r_held != MARK_NONE) begin
            n_held = MARK_NONE;
            if (f_letter(i_text_byte)) begin
                if (r_held == MARK_APOS && f_contraction(w_ctx.word)) begin
                    w_ctx = f_emit(w_ctx, KIND_BYTE, w_mark);
                    w_ctx = f_close(w_ctx);
                end else begin
                    w_ctx = f_append(w_ctx, w_mark);
                end
            end else begin
                w_ctx = f_close(w_ctx);
                w_ctx = f_emit(w_ctx, KIND_BYTE, w_mark);
                w_ctx = f_emit(w_ctx, KIND_END_TOKEN, 8'h00);
            end
        end

        // handle the byte itself
        if (f_word_byte(i_text_byte)) begin
            w_ctx = f_append(w_ctx, i_text_byte);
        end else if ((i_text_byte == CH_APOS || i_text_byte == CH_HYPHEN) &&
                     w_ctx.word.len != 2'd0 && !i_final_byte) begin
            n_held = (i_text_byte == CH_APOS) ? MARK_APOS : MARK_HYPHEN;
        end else begin
            w_ctx = f_close(w_ctx);
            if (!f_white(i_text_byte)) begin
                w_ctx = f_emit(w_ctx, KIND_BYTE, i_text_byte);
                w_ctx = f_emit(w_ctx, KIND_END_TOKEN, 8'h00);
            end
        end

        // flush at text end and return to reset state
        if (i_final_byte) begin
            w_ctx  = f_close(w_ctx);
            w_ctx  = f_emit(w_ctx, KIND_END_TEXT, 8'h00);
            n_held = MARK_NONE;
        end

        n_word = w_ctx.word;
    end

    assign o_push_plan  = w_ctx.plan;
    assign o_push_valid = i_in_valid && (w_ctx.plan.count != 3'd0);

    // advance word state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= MARK_NONE;
            r_word <= '0;
        end else if (w_accept) begin
            r_held <= n_held;
            r_word <= n_word;
        end
    end

endmodule

@@ design/tws_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_queue
// Two-entry queue of result plans between the front and the back end.
// ----------------------------------------------------------------------------
module tws_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  tws_pkg::t_plan i_push_plan,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output tws_pkg::t_plan o_pop_plan
);
    import tws_pkg::*;

    t_plan      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_plan   = r_mem[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // store pushed plans
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_plan;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

@@ design/tws_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_back
// Walks each result plan one slot per cycle, unless the output stalls, into
// the output register and flags the last result of every input byte.
// ----------------------------------------------------------------------------
module tws_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  tws_pkg::t_plan i_pop_plan,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_value,
    output logic           o_run_last
);
    import tws_pkg::*;

    t_plan      r_plan;
    logic [2:0] r_idx;
    logic       r_busy;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_value;
    logic       r_run_last;
    logic       w_emit, w_last, w_take;

    assign w_emit      = r_busy && (!r_out_valid || i_out_ready);
    assign w_last      = (r_idx == 3'(r_plan.count - 3'd1));
    assign w_take      = !r_busy || (w_emit && w_last);
    assign o_pop_ready = w_take;

    // load the next plan as the current one drains
    always_ff @(posedge i_clk) begin
        if (w_take && i_pop_valid) begin
            r_plan <= i_pop_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (w_take) begin
            r_busy <= i_pop_valid;
            r_idx  <= 3'd0;
        end else if (w_emit) begin
            r_idx  <= r_idx + 3'd1;
        end
    end

    // output register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_kind     <= r_plan.slot[r_idx].kind;
            r_value    <= r_plan.slot[r_idx].value;
            r_run_last <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_run_last  = r_run_last;

endmodule

@@ design/text_word_splitter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_word_splitter_core
// Streaming word splitter: text bytes in, token bytes and token/text end
// markers out.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_ready   | i_text_byte, i_final_byte
//   out     | output    | o_out_valid / i_out_ready | o_kind, o_value, o_run_last
//
// The front takes one byte per cycle while the two-entry plan queue has
// room; a byte causing n results holds the back end until all n are emitted at
// one result per cycle unless the output stalls. A held mark gives no results.
// Reset (synchronous, active low) clears word state, queue and output valid.
// Output stalls hold the output register and back up through the queue.
// ----------------------------------------------------------------------------
module text_word_splitter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_value,
    output logic       o_run_last
);
    import tws_pkg::*;

    logic  w_push_valid, w_push_ready;
    t_plan w_push_plan;
    logic  w_pop_valid, w_pop_ready;
    t_plan w_pop_plan;

    // classify bytes and build result plans
    tws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_plan  (w_push_plan)
    );

    // decouple front and back
    tws_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_plan  (w_push_plan),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_plan   (w_pop_plan)
    );

    // serialise plans into result beats
    tws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_plan  (w_pop_plan),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_run_last  (o_run_last)
    );

endmodule

@@ test/tb_text_word_splitter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_word_splitter_core
// Self-checking bench for the text word splitter. A short stimulus table
// covers field extremes, contractions, held marks, whitespace and text end.
// Random text then runs through three idling phases. The phases include one
// long output hold-off, so the block fills and back-pressures its input.
// Every result beat is checked field by field against an in-bench
// tokeniser model, or against values typed into the table.
// ----------------------------------------------------------------------------
module tb_text_word_splitter_core;

    import tws_pkg::*;

    localparam int QUIET_LIMIT    = 2000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES    = 80;    // long output hold-off
    localparam int DRAIN_CYCLES   = 20;
    localparam int RAND_PER_PHASE = 34;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       run_last;
    } t_tok;

    typedef struct packed {
        logic [7:0]      text;
        logic            fin;
        logic [1:0]      n_typed;  // 0: use the model
        t_res [2:0]      typed;
    } t_dir_row;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_text_byte  = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_value;
    logic       o_run_last;

    // tokeniser state of the model
    logic [1:0] held_mk;
    logic [1:0] word_len;
    logic [7:0] first_b;
    logic [7:0] second_b;

    t_tok     byte_toks[$];     // results of the byte being modelled
    t_tok     pending_toks[$];  // results still due from the block
    t_dir_row dir_tab[$];

    int  mismatch_cnt = 0;
    int  quiet_cnt    = 0;
    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    bit  hold_off_req = 1'b0;

    text_word_splitter_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_value      (o_value),
        .o_run_last   (o_run_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tokeniser model
    // ------------------------------------------------------------------
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    task automatic put_tok(input logic [1:0] k, input logic [7:0] v);
        t_tok t;
        t.kind     = k;
        t.value    = v;
        t.run_last = 1'b0;
        if (byte_toks.size() < MAX_RES)
            byte_toks.insert(byte_toks.size(), t);
    endtask

    task automatic grow_word(input logic [7:0] b);
        put_tok(KIND_BYTE, b);
        if (word_len == 2'd0)
            first_b = b;
        else if (word_len == 2'd1)
            second_b = b;
        if (word_len != 2'd3)
            word_len = word_len + 2'd1;
    endtask

    task automatic shut_word();
        if (word_len != 2'd0)
            put_tok(KIND_END_TOKEN, 8'h00);
        word_len = 2'd0;
        first_b  = 8'h00;
        second_b = 8'h00;
    endtask

    task automatic clear_splitter();
        held_mk  = MARK_NONE;
        word_len = 2'd0;
        first_b  = 8'h00;
        second_b = 8'h00;
    endtask

    // Work out the result beats for one text byte into byte_toks
    task automatic split_byte(input logic [7:0] c, input logic fin);
        logic [7:0] mk;
        logic       short_form;
        byte_toks.delete();
        // settle a held mark before the new byte
        if (held_mk != MARK_NONE) begin
            mk      = (held_mk == MARK_APOS) ? CH_APOS : CH_HYPHEN;
            held_mk = MARK_NONE;
            case (fold_case(first_b))
                "l", "d", "c", "j", "m", "t", "s", "n": short_form = (word_len == 2'd1);
                "q": short_form = (word_len == 2'd2) && (fold_case(second_b) == "u");
                default: short_form = 1'b0;
            endcase
            if (is_alpha(c)) begin
                if (mk == CH_APOS && short_form) begin
                    put_tok(KIND_BYTE, mk);
                    shut_word();
                end else begin
                    grow_word(mk);
                end
            end else begin
                shut_word();
                put_tok(KIND_BYTE, mk);
                put_tok(KIND_END_TOKEN, 8'h00);
            end
        end
        // handle the new byte itself
        if (c >= 8'h80 || is_alpha(c) || (c >= "0" && c <= "9")) begin
            grow_word(c);
        end else if ((c == CH_APOS || c == CH_HYPHEN) && word_len != 2'd0 && !fin) begin
            held_mk = (c == CH_APOS) ? MARK_APOS : MARK_HYPHEN;
        end else begin
            shut_word();
            if (!(c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))) begin
                put_tok(KIND_BYTE, c);
                put_tok(KIND_END_TOKEN, 8'h00);
            end
        end
        // close the text
        if (fin) begin
            shut_word();
            put_tok(KIND_END_TEXT, 8'h00);
            clear_splitter();
        end
        if (byte_toks.size() != 0)
            byte_toks[byte_toks.size() - 1].run_last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_row(input logic [7:0] b, input logic fin, input logic [1:0] n,
                           input t_res r0, input t_res r1, input t_res r2);
        t_dir_row row;
        row.text    = b;
        row.fin     = fin;
        row.n_typed = n;
        row.typed   = {r2, r1, r0};
        dir_tab.insert(dir_tab.size(), row);
    endtask

    // Text-like byte: mostly letters, marks and spaces, some anything
    function automatic logic [7:0] pick_text_byte();
        string      lead;
        logic [7:0] c;
        int         r;
        lead = "ldcjmtsnqu";
        r    = $urandom_range(99);
        if (r < 12) begin
            c = lead[$urandom_range(9)];
            if ($urandom_range(1) == 0)
                c = c & 8'hDF;
        end else if (r < 40) begin
            c = ($urandom_range(1) == 0) ? 8'("A" + $urandom_range(25))
                                         : 8'("a" + $urandom_range(25));
        end else if (r < 50) begin
            c = CH_APOS;
        end else if (r < 56) begin
            c = CH_HYPHEN;
        end else if (r < 70) begin
            c = ($urandom_range(2) != 0) ? CH_SPACE : 8'(9 + $urandom_range(4));
        end else if (r < 75) begin
            c = 8'("0" + $urandom_range(9));
        end else if (r < 85) begin
            c = 8'($urandom_range(255, 128));
        end else begin
            c = 8'($urandom_range(127));
        end
        return c;
    endfunction

    // Offer one byte, wait for its beat, then queue its expected results.
    // Entered and left just after a falling edge.
    task automatic offer_byte(input logic [7:0] b, input logic fin, input logic [1:0] n_typed,
                              input t_res [2:0] typed);
        t_tok t;
        int   i;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_text_byte  <= b;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        split_byte(b, fin);
        if (n_typed == 2'd0) begin
            foreach (byte_toks[k])
                pending_toks.insert(pending_toks.size(), byte_toks[k]);
        end else begin
            for (i = 0; i < n_typed; i++) begin
                t.kind     = typed[i].kind;
                t.value    = typed[i].value;
                t.run_last = (i == n_typed - 1);
                pending_toks.insert(pending_toks.size(), t);
            end
        end
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    // ------------------------------------------------------------------
    // Input side: reset, stimulus table, random phases, end of run
    // ------------------------------------------------------------------
    initial begin
        clear_splitter();
        // punctuation straight after reset
        add_row(8'h2C, 1'b0, 2'd2, {KIND_BYTE, 8'h2C}, {KIND_END_TOKEN, 8'h00}, '0);
        // single-letter contraction, then the qu contraction
        add_row("L",   1'b0, 2'd0, '0, '0, '0);
        add_row(CH_APOS, 1'b0, 2'd0, '0, '0, '0);
        add_row("a",   1'b0, 2'd0, '0, '0, '0);
        add_row(CH_SPACE, 1'b0, 2'd0, '0, '0, '0);
        add_row("q",   1'b0, 2'd0, '0, '0, '0);
        add_row("U",   1'b0, 2'd0, '0, '0, '0);
        add_row(CH_APOS, 1'b0, 2'd0, '0, '0, '0);
        add_row("x",   1'b0, 2'd0, '0, '0, '0);
        add_row(CH_SPACE, 1'b0, 2'd0, '0, '0, '0);
        // hyphen joins a word before a letter
        add_row("a",   1'b0, 2'd0, '0, '0, '0);
        add_row("b",   1'b0, 2'd0, '0, '0, '0);
        add_row(CH_HYPHEN, 1'b0, 2'd0, '0, '0, '0);
        add_row("C",   1'b0, 2'd0, '0, '0, '0);
        add_row(8'h09, 1'b0, 2'd0, '0, '0, '0);
        // mark with no open word
        add_row(CH_HYPHEN, 1'b0, 2'd2, {KIND_BYTE, CH_HYPHEN}, {KIND_END_TOKEN, 8'h00}, '0);
        // held mark followed by a digit falls back to punctuation
        add_row("7",   1'b0, 2'd0, '0, '0, '0);
        add_row(CH_APOS, 1'b0, 2'd0, '0, '0, '0);
        add_row("9",   1'b0, 2'd0, '0, '0, '0);
        add_row(8'h0D, 1'b0, 2'd0, '0, '0, '0);
        // mark as the last byte is never held
        add_row("z",   1'b0, 2'd0, '0, '0, '0);
        add_row(CH_APOS, 1'b1, 2'd0, '0, '0, '0);
        // byte extremes as one-byte texts
        add_row(8'h00, 1'b1, 2'd3, {KIND_BYTE, 8'h00}, {KIND_END_TOKEN, 8'h00},
                {KIND_END_TEXT, 8'h00});
        add_row(8'hFF, 1'b1, 2'd3, {KIND_BYTE, 8'hFF}, {KIND_END_TOKEN, 8'h00},
                {KIND_END_TEXT, 8'h00});
        // six results from one byte: held mark, punctuation and text end
        add_row("d",   1'b0, 2'd0, '0, '0, '0);
        add_row("e",   1'b0, 2'd0, '0, '0, '0);
        add_row(CH_APOS, 1'b0, 2'd0, '0, '0, '0);
        add_row(8'h2C, 1'b1, 2'd0, '0, '0, '0);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct = 35;
        snk_idle_pct = 62;
        foreach (dir_tab[k])
            offer_byte(dir_tab[k].text, dir_tab[k].fin, dir_tab[k].n_typed, dir_tab[k].typed);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 35; snk_idle_pct = 62; end
                1: begin src_idle_pct = 62; snk_idle_pct = 35; end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    hold_off_req = 1'b1;
                end
            endcase
            repeat (RAND_PER_PHASE)
                offer_byte(pick_text_byte(), $urandom_range(14) == 0, 2'd0, '0);
        end
        i_in_valid <= 1'b0;

        // drain, then let any stray beat show up
        while (pending_toks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("tb_text_word_splitter_core: clean");
        else
            $display("tb_text_word_splitter_core: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Check each output beat against the oldest pending result
    always @(posedge i_clk) begin
        t_tok want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_toks.size() == 0) begin
                report_mismatch("beat with nothing pending, kind", o_kind, -1);
            end else begin
                want = pending_toks.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", o_kind, want.kind);
                if (o_value !== want.value)
                    report_mismatch("value", o_value, want.value);
                if (o_run_last !== want.run_last)
                    report_mismatch("run_last", o_run_last, want.run_last);
            end
        end
    end

    // Stop a hung run: count cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= QUIET_LIMIT) begin
            $display("tb_text_word_splitter_core: errors");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

endmodule
